// ===== rtl/vzd_pkg.sv =====
// Package for the varint/zigzag decoder: shared types, register indexes and constants.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
package vzd_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAYLOAD_W   = 7;
  localparam int unsigned SHIFT_W     = 6;   // stored shift is always below 64
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SHIFT_W:0] LAST_SHIFT_WIDE   = 7'd63;
  localparam logic [SHIFT_W:0] LAST_SHIFT_NARROW = 7'd31;
  localparam logic [SHIFT_W:0] GROUP_STEP        = 7'd7;

  localparam logic [VALUE_W-1:0] MASK_WIDE   = {VALUE_W{1'b1}};
  localparam logic [VALUE_W-1:0] MASK_NARROW = {{(VALUE_W-32){1'b0}}, {32{1'b1}}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'b1;

  // Result status codes.
  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  typedef struct packed {
    logic wide_mode;
    logic signed_mode;
  } vzd_cfg_t;

  // One classified result waiting between the front and the back.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
    logic               wide_mode;
    logic               signed_mode;
  } vzd_item_t;

endpackage

// ===== rtl/vzd_front.sv =====
// Front end of the varint decoder: takes bytes, gathers 7-bit groups and classifies results.
// Depends on vzd_pkg.
`timescale 1ns / 1ps
module vzd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vzd_pkg::vzd_cfg_t            cfg,
  input  logic                         byte_valid,
  input  logic [vzd_pkg::BYTE_W-1:0]   byte_data,
  input  logic                         queue_full,
  output logic                         byte_ready,
  output logic                         push,
  output vzd_pkg::vzd_item_t           push_item
);
  import vzd_pkg::*;

  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [VALUE_W-1:0] mask;
  logic [VALUE_W-1:0] placed;
  logic [VALUE_W-1:0] merged;
  logic [SHIFT_W:0]   shift_sum;
  logic [SHIFT_W:0]   last_shift;
  logic               accept;
  logic               cont;
  logic               too_long;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign cont       = byte_data[BYTE_W-1];
  assign mask       = cfg.wide_mode ? MASK_WIDE : MASK_NARROW;
  assign last_shift = cfg.wide_mode ? LAST_SHIFT_WIDE : LAST_SHIFT_NARROW;
  assign placed     = ({{(VALUE_W-PAYLOAD_W){1'b0}}, byte_data[PAYLOAD_W-1:0]} << shift_r)
                      & mask;
  assign merged     = acc_r | placed;
  assign shift_sum  = {1'b0, shift_r} + GROUP_STEP;
  assign too_long   = shift_sum > last_shift;

  always_comb begin
    acc_nxt               = acc_r;
    shift_nxt             = shift_r;
    push                  = 1'b0;
    push_item.value       = merged & mask;
    push_item.status      = STATUS_DONE;
    push_item.wide_mode   = cfg.wide_mode;
    push_item.signed_mode = cfg.signed_mode;
    if (accept) begin
      if (!cont) begin
        push      = 1'b1;
        acc_nxt   = '0;
        shift_nxt = '0;
      end else if (too_long) begin
        push             = 1'b1;
        push_item.value  = '0;
        push_item.status = STATUS_TOO_LONG;
        acc_nxt          = '0;
        shift_nxt        = '0;
      end else begin
        acc_nxt   = merged;
        shift_nxt = shift_sum[SHIFT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      shift_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

// ===== rtl/vzd_queue.sv =====
// Short result queue between the front and back of the varint decoder.
// Depends on vzd_pkg.
`timescale 1ns / 1ps
module vzd_queue #(
  parameter int unsigned DEPTH = vzd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vzd_pkg::vzd_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output vzd_pkg::vzd_item_t head_item
);
  import vzd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  vzd_item_t         mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/vzd_back.sv =====
// Back end of the varint decoder: zigzag decode and the registered result stage.
// Depends on vzd_pkg.
`timescale 1ns / 1ps
module vzd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  vzd_pkg::vzd_item_t           head_item,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [vzd_pkg::VALUE_W-1:0]  res_value,
  output logic                         res_status
);
  import vzd_pkg::*;

  logic               valid_r, valid_nxt;
  logic [VALUE_W-1:0] value_r;
  logic               status_r;
  logic [VALUE_W-1:0] mask;
  logic [VALUE_W-1:0] sign_fill;
  logic [VALUE_W-1:0] decoded;

  assign mask      = head_item.wide_mode ? MASK_WIDE : MASK_NARROW;
  assign sign_fill = {VALUE_W{head_item.value[0]}};

  always_comb begin
    decoded = head_item.value;
    if (head_item.signed_mode && (head_item.status == STATUS_DONE)) begin
      decoded = ((head_item.value >> 1) ^ sign_fill) & mask;
    end
  end

  assign pop = head_valid && (!valid_r || res_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value_r  <= decoded;
      status_r <= head_item.status;
    end
  end

  assign res_valid  = valid_r;
  assign res_value  = value_r;
  assign res_status = status_r;

endmodule

// ===== rtl/varint_zigzag_decoder_unit.sv =====
// Top level of the LEB128 varint decoder with optional zigzag decoding.
// Depends on vzd_pkg, vzd_front, vzd_queue and vzd_back.
`timescale 1ns / 1ps
// How to use this block:
// Encoded bytes enter on the in_ stream, one byte per beat, least significant
// 7-bit group first; bit 7 of a byte marks that more bytes follow. Each byte
// that ends an integer produces one beat on the out_ stream carrying the
// decoded value in out_tdata and a status flag in out_tuser (0 for a complete
// integer, 1 for an integer that ran past 5 bytes in 32-bit mode or 10 bytes
// in 64-bit mode; such an integer is dropped and its value reads as zero).
// Bytes that continue an integer produce no beat.
// The two mode registers are written through the cfg_ port (index 0 selects
// 32 or 64-bit integers, index 1 turns on zigzag decoding) and must only be
// changed while no result is outstanding.
// A result is written into the result queue by the edge that accepts its last
// byte, and moves from there into the output register, which drives
// out_tvalid. One byte is taken every cycle while the result queue is not
// full, since the accumulate step is a single mask, shift and OR held in the
// front end.
// When the receiver stalls, the output register holds its beat and the
// two-entry queue keeps absorbing results; in_tready drops only once the
// queue is full. A synchronous reset clears the accumulator, the queue and
// the output stage and restores 64-bit unsigned mode.
module varint_zigzag_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = vzd_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream; in_tdata: [7:0] in_byte.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [vzd_pkg::BYTE_W-1:0]       in_tdata,
  // Result stream; out_tdata: [63:0] value; out_tuser: [0] status.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [vzd_pkg::VALUE_W-1:0]      out_tdata,
  output logic                             out_tuser,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [vzd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vzd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vzd_pkg::*;

  vzd_cfg_t  cfg_r, cfg_nxt;
  vzd_item_t push_item;
  vzd_item_t head_item;
  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_not_empty;

  // Mode registers; only bit 0 of the write data is kept.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_WIDE_MODE:   cfg_nxt.wide_mode   = cfg_wdata[0];
        REG_SIGNED_MODE: cfg_nxt.signed_mode = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide_mode   <= 1'b1;
      cfg_r.signed_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vzd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (in_tvalid),
    .byte_data  (in_tdata),
    .queue_full (queue_full),
    .byte_ready (in_tready),
    .push       (push),
    .push_item  (push_item)
  );

  vzd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head_item (head_item)
  );

  vzd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (queue_not_empty),
    .head_item  (head_item),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_value  (out_tdata),
    .res_status (out_tuser)
  );

endmodule

// ===== rtl/vzd_checker.sv =====
// Port-level checker for the varint decoder and its bind to the top level.
// Depends on vzd_pkg and varint_zigzag_decoder_unit.
`timescale 1ns / 1ps
module vzd_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [vzd_pkg::VALUE_W-1:0]      out_tdata,
  input  logic                             out_tuser
);
  import vzd_pkg::*;

  // Reset empties the output stage.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // A dropped integer always reports a zero value.
  a_too_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_TOO_LONG) |-> out_tdata == '0)
    else $error("too-long result carries a nonzero value");

endmodule

bind varint_zigzag_decoder_unit vzd_checker u_vzd_checker (.*);

// ===== dv/tb_varint_zigzag_decoder_unit.sv =====
// Self-checking testbench for varint_zigzag_decoder_unit: a directed table, then random phases.
// A cycle-free decoder model predicts each result. Depends on vzd_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_varint_zigzag_decoder_unit;
  import vzd_pkg::*;

  // A full receiver hold-off must fit well inside the idle limit.
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned IDLE_PCT      = 32;
  localparam int unsigned PHASE_BYTES   = 135;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } result_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // One line of the directed table. A register write uses reg_idx and reg_data;
  // a byte uses octet, and carries a typed result when checked is set.
  typedef struct {
    row_kind_t              kind;
    logic [BYTE_W-1:0]      octet;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic                   reg_data;
    bit                     checked;
    result_t                want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;    // [7:0] in_byte
  logic                  out_tvalid;
  logic                  out_tready;
  logic [VALUE_W-1:0]    out_tdata;   // [63:0] value
  logic                  out_tuser;   // [0] status
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  varint_zigzag_decoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Decoder state as the block should hold it, together with its mode registers.
  logic [VALUE_W-1:0] pred_acc    = '0;
  logic [SHIFT_W:0]   pred_shift  = '0;
  logic               pred_wide   = 1'b1;
  logic               pred_signed = 1'b0;

  result_t     pending_values[$];
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_requests = 0;
  bit          steady        = 1'b0;

  // Directed table. It starts in the reset modes: 64-bit, unsigned.
  stim_row_t directed_rows [27] = '{
    // Smallest and largest single-byte integers.
    '{ROW_BYTE, 8'h00, REG_WIDE_MODE, 1'b0, 1'b1, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'h7F, REG_WIDE_MODE, 1'b0, 1'b1, '{64'h7F, STATUS_DONE}},
    // Ten-byte all-ones integer; the last group lands at bit 63, so six of its
    // payload bits fall above the 64-bit width and are dropped.
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'h7F, REG_WIDE_MODE, 1'b0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, STATUS_DONE}},
    // Five continuation bytes in 64-bit mode, then a switch to 32-bit mode in the
    // middle of the integer: the shift already lies past 31, so the next
    // continuation byte makes the integer too long.
    '{ROW_BYTE, 8'h80, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'h80, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'h80, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'h80, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'h80, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_CFG,  8'h00, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'h80, REG_WIDE_MODE, 1'b0, 1'b1, '{64'h0, STATUS_TOO_LONG}},
    // Five-byte all-ones integer in 32-bit mode; bits above 31 are dropped.
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'hFF, REG_WIDE_MODE, 1'b0, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'h7F, REG_WIDE_MODE, 1'b0, 1'b1, '{64'hFFFF_FFFF, STATUS_DONE}},
    // Zigzag of 1 is -1, which stays within the low 32 bits.
    '{ROW_CFG,  8'h00, REG_SIGNED_MODE, 1'b1, 1'b0, '{64'h0, STATUS_DONE}},
    '{ROW_BYTE, 8'h01, REG_WIDE_MODE, 1'b0, 1'b1, '{64'hFFFF_FFFF, STATUS_DONE}},
    '{ROW_CFG,  8'h00, REG_WIDE_MODE, 1'b1, 1'b0, '{64'h0, STATUS_DONE}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decodes one byte into the predicted state. Returns 1 when the byte ends an
  // integer, either complete or too long, with the result in res.
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output result_t res);
    logic [VALUE_W-1:0] mask;
    logic [SHIFT_W:0]   last;
    logic [VALUE_W-1:0] v;
    mask = pred_wide ? MASK_WIDE : MASK_NARROW;
    last = pred_wide ? LAST_SHIFT_WIDE : LAST_SHIFT_NARROW;
    res  = '0;
    if (pred_shift < 7'd64) begin
      pred_acc = pred_acc | (({{(VALUE_W-PAYLOAD_W){1'b0}}, b[PAYLOAD_W-1:0]} << pred_shift)
                             & mask);
    end
    if (!b[BYTE_W-1]) begin
      v = pred_acc & mask;
      if (pred_signed) begin
        v = ((v >> 1) ^ {VALUE_W{v[0]}}) & mask;
      end
      res = '{v, STATUS_DONE};
      pred_acc   = '0;
      pred_shift = '0;
      return 1'b1;
    end
    pred_shift = pred_shift + GROUP_STEP;
    if (pred_shift > last) begin
      res = '{'0, STATUS_TOO_LONG};
      pred_acc   = '0;
      pred_shift = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Payload groups lean toward the all-zero and all-one patterns.
  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PAYLOAD_W'($urandom);
  endfunction

  // Offers one byte, after a random number of idle cycles unless the sender is
  // in a steady stretch, and returns right after the edge that accepts it. The
  // expected result is the typed one when checked is set, else the prediction.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit checked, input result_t typed);
    result_t res;
    bit      got;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    got = decode_byte(b, res);
    if (checked) begin
      pending_values = {pending_values, typed};
    end else if (got) begin
      pending_values = {pending_values, res};
    end
  endtask

  // Registers change only with nothing outstanding. A continuation byte gives no
  // result, so an extra settling wait lets the front end finish with it first.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic d);
    in_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDE_MODE) begin
      pred_wide = d;
    end else begin
      pred_signed = d;
    end
  endtask

  // Random traffic: mostly well-formed integers of random length and content,
  // some runs of continuation bytes that are too long, and some loose bytes.
  task automatic run_phase(input int unsigned nbytes);
    int unsigned sent;
    int unsigned roll;
    int unsigned len;
    int unsigned max_len;
    int unsigned k;
    bit          too_long;
    logic        cont;
    sent = 0;
    while (sent < nbytes) begin
      max_len = pred_wide ? 10 : 5;
      roll    = $urandom_range(99);
      if (roll < 8) begin
        send_byte(BYTE_W'($urandom_range(255)), 1'b0, '0);
        sent++;
      end else begin
        too_long = (roll < 18);
        if (too_long || $urandom_range(3) == 0) begin
          len = max_len;
        end else begin
          len = $urandom_range(max_len, 1);
        end
        for (k = 0; k < len; k++) begin
          cont = too_long || (k != len - 1);
          send_byte({cont, pick_payload()}, 1'b0, '0);
        end
        sent += len;
      end
    end
  endtask

  // Receiver: stalls at random, except in a steady stretch, and on request holds
  // off for a long stretch so the result queue fills and the input stalls.
  initial begin
    int unsigned hold_served;
    hold_served = 0;
    out_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Each result beat is compared with the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_values.size() == 0) begin
        $display("%0t: result with nothing expected: value %h status %0d",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = pending_values.pop_front();
        if (out_tdata !== want.value) begin
          $display("%0t: value mismatch: expected %h actual %h", $time, want.value, out_tdata);
          mismatches++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: the run ends if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned p;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_byte(directed_rows[i].octet, directed_rows[i].checked, directed_rows[i].want);
      end
    end

    // Eight phases walk all four mode settings twice. Every phase starts with
    // writes made after the sender has paused for all results. Phase 1 holds
    // off the receiver; phase 3 runs both sides without idling.
    for (p = 0; p < 8; p++) begin
      write_reg(REG_WIDE_MODE, p[0]);
      write_reg(REG_SIGNED_MODE, p[1]);
      steady = (p == 3);
      if (p == 1) begin
        hold_requests++;
      end
      run_phase(PHASE_BYTES);
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
